// ----- hw/rtl/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int DEPTH_W         = 7;
  localparam int ACT_W           = 3;
  localparam int ST_W            = 3;
  localparam int CNT_W           = 5;
  localparam int DefStackDepth   = 64;

  localparam logic [ACT_W-1:0] ACT_POP   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MUL   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DIV   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SUB   = 3'd6;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [ST_W-1:0] ST_OVER    = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVZ    = 3'd3;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] push_value;
  } rpn_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] popped_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [ST_W-1:0]          status;
  } rpn_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rpn_stack_calculator_top.sv -----
// Channel  | Direction | Ports                 | Handshake
// command  | in        | cmd_i                 | taken when start && !busy
// result   | out       | res_o                 | one-cycle strobe res_valid_o
//
// Push, clear, invalid commands and all underflow/overflow cases: busy stays low,
// result on the cycle after the item is taken. Pop: busy in S_TOP (stack read).
// Add/subtract: busy in S_LOAD, S_WB. Multiply/divide: S_LOAD, S_EXEC, S_WB;
// S_EXEC steps the shared 33-bit adder one bit per cycle (shift-add, restoring
// divide). Divide by zero: S_LOAD, S_TOP. Reset empties the stack at once; the
// stack memory itself is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rpn_pkg::DefStackDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire rpn_pkg::rpn_cmd_t cmd_i,
  output logic                   res_valid_o,
  output rpn_pkg::rpn_res_t      res_o
);
  import rpn_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_TOP  = 3'd4;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [2:0]        state_q, state_d;
  logic [SPW-1:0]    sp_q, sp_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [ACT_W-1:0]  op_q, op_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] opb_q, opb_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic [DATA_W-1:0] popped_q, popped_d;
  logic              res_valid_q, res_valid_d;
  rpn_res_t          res_q, res_d;

  logic [DATA_W-1:0] rd_q;
  logic [AW-1:0]     raddr, waddr;
  logic              we;
  logic [DATA_W-1:0] wdata;

  logic [SPW-1:0]    sp_m1, sp_m2, sp_m3, sp_p1;
  logic              accept;
  logic [DATA_W:0]   add_a, add_b, sum;
  logic              add_sub;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W-1:0] y_mag, x_mag, wb_val;

  function automatic rpn_res_t make_res(logic [SPW-1:0] sp, logic [DATA_W-1:0] top,
                                        logic [DATA_W-1:0] popped, logic [ST_W-1:0] st);
    rpn_res_t r;
    r.top_value    = (sp == '0) ? '0 : top;
    r.popped_value = popped;
    r.stack_depth  = DEPTH_W'(sp);
    r.status       = st;
    return r;
  endfunction

  assign accept = start && !busy;
  assign sp_m1  = sp_q - SPW'(1);
  assign sp_m2  = sp_q - SPW'(2);
  assign sp_m3  = sp_q - SPW'(3);
  assign sp_p1  = sp_q + SPW'(1);

  assign rem_sh = {acc_q, quo_q[DATA_W-1]};
  assign y_mag  = rd_q[DATA_W-1] ? (~rd_q + 1'b1) : rd_q;
  assign x_mag  = top_q[DATA_W-1] ? (~top_q + 1'b1) : top_q;
  assign wb_val = (op_q != ACT_DIV) ? acc_q : (neg_q ? (~quo_q + 1'b1) : quo_q);

  // shared adder/subtractor
  always_comb begin
    add_a   = {1'b0, rd_q};
    add_b   = {1'b0, top_q};
    add_sub = (op_q == ACT_SUB);
    if (state_q == S_EXEC) begin
      if (op_q == ACT_DIV) begin
        add_a   = rem_sh;
        add_b   = {1'b0, opb_q};
        add_sub = 1'b1;
      end else begin
        add_a   = {1'b0, acc_q};
        add_b   = {1'b0, opb_q};
        add_sub = 1'b0;
      end
    end
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + (DATA_W+1)'(add_sub);

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    top_d       = top_q;
    op_d        = op_q;
    acc_d       = acc_q;
    opb_d       = opb_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    status_d    = status_q;
    popped_d    = popped_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    raddr       = sp_m2[AW-1:0];
    we          = 1'b0;
    waddr       = sp_q[AW-1:0];
    wdata       = cmd_i.push_value;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = cmd_i.action;
          unique case (cmd_i.action)
            ACT_POP: begin
              if (sp_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = make_res(sp_q, top_q, '0, ST_UNDER);
              end else begin
                popped_d = top_q;
                status_d = ST_OK;
                sp_d     = sp_m1;
                state_d  = S_TOP;
              end
            end
            ACT_PUSH: begin
              res_valid_d = 1'b1;
              if (sp_q == SPW'(STACK_DEPTH)) begin
                res_d = make_res(sp_q, top_q, '0, ST_OVER);
              end else begin
                we    = 1'b1;
                top_d = cmd_i.push_value;
                sp_d  = sp_p1;
                res_d = make_res(sp_p1, cmd_i.push_value, '0, ST_OK);
              end
            end
            ACT_CLEAR: begin
              sp_d        = '0;
              res_valid_d = 1'b1;
              res_d       = make_res('0, top_q, '0, ST_OK);
            end
            ACT_ADD, ACT_MUL, ACT_DIV, ACT_SUB: begin
              if (sp_q < SPW'(2)) begin
                res_valid_d = 1'b1;
                res_d       = make_res(sp_q, top_q, '0, ST_UNDER);
              end else begin
                state_d = S_LOAD;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = make_res(sp_q, top_q, '0, ST_INVALID);
            end
          endcase
        end
      end
      S_LOAD: begin
        cnt_d = '0;
        priority if (op_q == ACT_MUL) begin
          acc_d   = '0;
          opb_d   = rd_q;
          quo_d   = top_q;
          state_d = S_EXEC;
        end else if (op_q == ACT_DIV && top_q == '0) begin
          raddr    = sp_m3[AW-1:0];
          sp_d     = sp_m2;
          status_d = ST_DIVZ;
          popped_d = '0;
          state_d  = S_TOP;
        end else if (op_q == ACT_DIV) begin
          acc_d   = '0;
          opb_d   = x_mag;
          quo_d   = y_mag;
          neg_d   = rd_q[DATA_W-1] ^ top_q[DATA_W-1];
          state_d = S_EXEC;
        end else begin
          acc_d   = sum[DATA_W-1:0];
          state_d = S_WB;
        end
      end
      S_EXEC: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == ACT_DIV) begin
          if (!sum[DATA_W]) begin
            acc_d = sum[DATA_W-1:0];
            quo_d = {quo_q[DATA_W-2:0], 1'b1};
          end else begin
            acc_d = rem_sh[DATA_W-1:0];
            quo_d = {quo_q[DATA_W-2:0], 1'b0};
          end
        end else begin
          if (quo_q[0]) begin
            acc_d = sum[DATA_W-1:0];
          end
          opb_d = {opb_q[DATA_W-2:0], 1'b0};
          quo_d = {1'b0, quo_q[DATA_W-1:1]};
        end
        if (cnt_q == '1) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        we          = 1'b1;
        waddr       = sp_m2[AW-1:0];
        wdata       = wb_val;
        top_d       = wb_val;
        sp_d        = sp_m1;
        res_valid_d = 1'b1;
        res_d       = make_res(sp_m1, wb_val, '0, ST_OK);
        state_d     = S_IDLE;
      end
      S_TOP: begin
        top_d       = rd_q;
        res_valid_d = 1'b1;
        res_d       = make_res(sp_q, rd_q, popped_q, status_q);
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    op_q     <= op_d;
    acc_q    <= acc_d;
    opb_q    <= opb_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    popped_q <= popped_d;
    res_q    <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |-> (cnt_q == '0))
    else $error("iteration counter running outside execute");

  a_strobe_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept || busy))
    else $error("result without an item in flight");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OVER) |-> (sp_q == SPW'(STACK_DEPTH)))
    else $error("overflow flagged on a stack that is not full");

endmodule

`default_nettype wire

// ----- tb/sv/rpn_result_checker.sv -----
`default_nettype none

module rpn_result_checker
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     busy_i,
  input  wire rpn_cmd_t cmd_i,
  input  wire logic     res_valid_i,
  input  wire rpn_res_t res_i,
  output int            fail_count_o,
  output int            pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                depth = 0;
  int                fails = 0;
  rpn_res_t          expected_results [$];
  rpn_res_t          oldest;

  function automatic rpn_res_t apply_command(rpn_cmd_t c);
    rpn_res_t          r;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] xm;
    logic [DATA_W-1:0] ym;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] popped;
    logic [ST_W-1:0]   st;
    st     = ST_OK;
    popped = '0;
    q      = '0;
    case (c.action)
      ACT_POP: begin
        if (depth == 0) begin
          st = ST_UNDER;
        end else begin
          depth--;
          popped = stack_mem[depth];
        end
      end
      ACT_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          st = ST_OVER;
        end else begin
          stack_mem[depth] = c.push_value;
          depth++;
        end
      end
      ACT_CLEAR: begin
        depth = 0;
      end
      ACT_ADD, ACT_MUL, ACT_DIV, ACT_SUB: begin
        if (depth < 2) begin
          st = ST_UNDER;
        end else begin
          x = stack_mem[depth-1];
          y = stack_mem[depth-2];
          depth -= 2;
          case (c.action)
            ACT_ADD: q = y + x;
            ACT_MUL: q = y * x;
            ACT_SUB: q = y - x;
            ACT_DIV: begin
              if (x == '0) begin
                st = ST_DIVZ;
              end else begin
                // truncate toward zero on magnitudes; MIN / -1 wraps to MIN
                ym = y[DATA_W-1] ? -y : y;
                xm = x[DATA_W-1] ? -x : x;
                q  = ym / xm;
                if (x[DATA_W-1] ^ y[DATA_W-1]) q = -q;
              end
            end
            default: q = '0;
          endcase
          if (st == ST_OK) begin
            stack_mem[depth] = q;
            depth++;
          end
        end
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
    r.top_value    = (depth > 0) ? stack_mem[depth-1] : '0;
    r.popped_value = popped;
    r.stack_depth  = DEPTH_W'(depth);
    r.status       = st;
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth = 0;
      expected_results.delete();
      pending_count_o <= 0;
      fail_count_o    <= fails;
    end else begin
      if (res_valid_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no command outstanding");
          fails++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("top_value", oldest.top_value, res_i.top_value);
          check_field("popped_value", oldest.popped_value, res_i.popped_value);
          check_field("stack_depth", DATA_W'(oldest.stack_depth), DATA_W'(res_i.stack_depth));
          check_field("status", DATA_W'(oldest.status), DATA_W'(res_i.status));
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_command(cmd_i));
      end
      fail_count_o    <= fails;
      pending_count_o <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_BAD        = 3'd7;
  localparam logic [DATA_W-1:0] MAX_VAL        = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MIN_VAL        = 32'h8000_0000;
  localparam logic [DATA_W-1:0] NEG_ONE        = 32'hffff_ffff;
  localparam int                RANDOM_ITEMS   = 1550;
  localparam int                QUIET_TAIL     = 200;
  localparam int                WATCHDOG_LIMIT = 2000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rpn_cmd_t cmd_i;
  logic     res_valid_o;
  rpn_res_t res_o;
  int       fail_count;
  int       pending_count;
  int       idle_cycles;
  int       gap_pct;
  int       push_pct;

  rpn_stack_calculator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  rpn_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_i),
    .res_valid_i    (res_valid_o),
    .res_i          (res_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic issue_command(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val);
    rpn_cmd_t c;
    c.action     = act;
    c.push_value = val;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic maybe_pause();
    int n;
    if ($urandom_range(99) < gap_pct) begin
      n = $urandom_range(1, 17);
      start <= 1'b0;
      cmd_i <= rpn_cmd_t'({$urandom(), $urandom()});
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: return r;
      4, 5, 6:    return $urandom_range(16) - 32'd8;
      7: begin
        case ($urandom_range(4))
          0:       return MAX_VAL;
          1:       return MIN_VAL;
          2:       return NEG_ONE;
          3:       return 32'd1;
          default: return '0;
        endcase
      end
      8:       return {{16{r[15]}}, r[15:0]};
      default: return '0;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int r;
    if ($urandom_range(99) < push_pct) return ACT_PUSH;
    r = $urandom_range(99);
    if (r < 3)  return ACT_CLEAR;
    if (r < 6)  return ACT_BAD;
    if (r < 26) return ACT_POP;
    if (r < 46) return ACT_ADD;
    if (r < 62) return ACT_MUL;
    if (r < 82) return ACT_DIV;
    return ACT_SUB;
  endfunction

  task automatic directed_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val);
    maybe_pause();
    issue_command(act, val);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    idle_cycles = 0;
    gap_pct     = 30;
    push_pct    = 50;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-stack underflows, wrap on add, MIN / -1, divide by zero, truncation
    directed_item(ACT_POP, '0);
    directed_item(ACT_ADD, '0);
    directed_item(ACT_PUSH, MAX_VAL);
    directed_item(ACT_SUB, '0);
    directed_item(ACT_PUSH, 32'd1);
    directed_item(ACT_ADD, '1);
    directed_item(ACT_PUSH, NEG_ONE);
    directed_item(ACT_DIV, '0);
    directed_item(ACT_PUSH, '0);
    directed_item(ACT_DIV, '0);
    directed_item(ACT_PUSH, 32'd7);
    directed_item(ACT_PUSH, -32'sd2);
    directed_item(ACT_DIV, '0);
    directed_item(ACT_PUSH, MIN_VAL);
    directed_item(ACT_MUL, '0);
    directed_item(ACT_PUSH, 32'h5555_aaaa);
    directed_item(ACT_SUB, '0);
    directed_item(ACT_BAD, 32'hdead_beef);
    directed_item(ACT_PUSH, -32'sd7);
    directed_item(ACT_PUSH, 32'd2);
    directed_item(ACT_DIV, '0);
    directed_item(ACT_POP, '0);
    directed_item(ACT_CLEAR, '0);
    directed_item(ACT_POP, '0);
    directed_item(ACT_MUL, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 88;
        endcase
        case ($urandom_range(2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) gap_pct = 0;
      maybe_pause();
      issue_command(pick_action(), pick_operand());
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_stack_calculator_top.sv
tb/sv/rpn_result_checker.sv
tb/sv/testbench.sv
